// ===== hdl/css_pkg.sv =====
// Package for the comment stripper: scanner state codes, result kinds, result record.
`default_nettype none
package css_pkg;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_BLOCK  = 3'd1,
        MODE_LINE   = 3'd2,
        MODE_STR    = 3'd3,
        MODE_CHR    = 3'd4,
        MODE_BSL    = 3'd5,
        MODE_DROP   = 3'd6
    } mode_t;

    typedef enum logic [1:0] {
        HELD_NONE  = 2'd0,
        HELD_SLASH = 2'd1,
        HELD_STAR  = 2'd2
    } held_t;

    localparam logic [2:0] KIND_DATA   = 3'd0;
    localparam logic [2:0] KIND_END    = 3'd1;
    localparam logic [2:0] KIND_STR    = 3'd2;
    localparam logic [2:0] KIND_CHR    = 3'd3;
    localparam logic [2:0] KIND_BSL    = 3'd4;

    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSL    = 8'h5C;
    localparam logic [7:0] CH_NL     = 8'h0A;

    localparam int MAX_RES = 3;
    localparam int Q_DEPTH = 4;

    typedef struct packed {
        logic [7:0] data;
        logic [2:0] kind;
        logic       last;
    } res_t;

    typedef res_t [MAX_RES-1:0] res_arr_t;

endpackage
`default_nettype wire

// ===== hdl/css_scan.sv =====
// Scanner: state register and the per-byte step that yields up to three results.
`default_nettype none
module css_scan (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            accept,
    input  wire logic [7:0]      in_byte,
    input  wire logic            in_last,
    output css_pkg::res_arr_t    res,
    output logic [1:0]           res_n
);
    import css_pkg::*;

    mode_t mode_reg, mode_next;
    held_t held_reg, held_next;
    logic  esc_reg, esc_next;

    function automatic res_arr_t put(res_arr_t r, logic [1:0] idx, res_t e);
        r[idx] = e;
        return r;
    endfunction

    always_comb
    begin
        res_t     e;
        logic     do_take;
        logic [2:0] end_kind;
        mode_next = mode_reg;
        held_next = held_reg;
        esc_next  = esc_reg;
        res       = '0;
        res_n     = 2'd0;
        do_take   = 1'b1;
        end_kind  = KIND_END;
        e         = '0;

        if (held_reg != HELD_NONE)
        begin
            held_next = HELD_NONE;
            if (held_reg == HELD_SLASH && in_byte == CH_STAR)
            begin
                mode_next = MODE_BLOCK;
                do_take   = 1'b0;
            end
            else if (held_reg == HELD_STAR && in_byte == CH_SLASH)
            begin
                mode_next = MODE_NORMAL;
                do_take   = 1'b0;
            end
            else if (held_reg == HELD_SLASH && in_byte == CH_SLASH && mode_reg == MODE_NORMAL)
            begin
                mode_next = MODE_LINE;
                do_take   = 1'b0;
            end
            else if (mode_reg == MODE_NORMAL)
            begin
                e.data = (held_reg == HELD_SLASH) ? CH_SLASH : CH_STAR;
                e.kind = KIND_DATA;
                e.last = 1'b0;
                res    = put(res, res_n, e);
                res_n  = res_n + 2'd1;
            end
        end

        if (do_take)
        begin
            case (mode_next)
                MODE_NORMAL, MODE_BLOCK:
                begin
                    e = '{data: in_byte, kind: KIND_DATA, last: 1'b0};
                    if (in_byte == CH_SLASH)
                        held_next = HELD_SLASH;
                    else if (in_byte == CH_STAR)
                        held_next = HELD_STAR;
                    else if (mode_next == MODE_BLOCK)
                        ;
                    else if (in_byte == CH_DQUOTE || in_byte == CH_SQUOTE)
                    begin
                        res       = put(res, res_n, e);
                        res_n     = res_n + 2'd1;
                        mode_next = (in_byte == CH_DQUOTE) ? MODE_STR : MODE_CHR;
                        esc_next  = 1'b0;
                    end
                    else if (in_byte == CH_BSL)
                        mode_next = MODE_BSL;
                    else
                    begin
                        res   = put(res, res_n, e);
                        res_n = res_n + 2'd1;
                    end
                end
                MODE_LINE:
                begin
                    if (in_byte == CH_NL)
                    begin
                        e         = '{data: in_byte, kind: KIND_DATA, last: 1'b0};
                        res       = put(res, res_n, e);
                        res_n     = res_n + 2'd1;
                        mode_next = MODE_NORMAL;
                    end
                end
                MODE_STR, MODE_CHR:
                begin
                    e     = '{data: in_byte, kind: KIND_DATA, last: 1'b0};
                    res   = put(res, res_n, e);
                    res_n = res_n + 2'd1;
                    if (esc_reg)
                        esc_next = 1'b0;
                    else if (in_byte == CH_BSL)
                        esc_next = 1'b1;
                    else if (in_byte == ((mode_next == MODE_STR) ? CH_DQUOTE : CH_SQUOTE))
                        mode_next = MODE_NORMAL;
                end
                MODE_BSL:
                begin
                    if (in_byte == CH_NL)
                        mode_next = MODE_NORMAL;
                    else
                    begin
                        e         = '{data: 8'h00, kind: KIND_BSL, last: 1'b1};
                        res       = put(res, res_n, e);
                        res_n     = res_n + 2'd1;
                        mode_next = MODE_DROP;
                    end
                end
                default:
                    ;
            endcase
        end

        if (in_last)
        begin
            if (mode_next != MODE_DROP)
            begin
                if (held_next != HELD_NONE && mode_next == MODE_NORMAL)
                begin
                    e.data = (held_next == HELD_SLASH) ? CH_SLASH : CH_STAR;
                    e.kind = KIND_DATA;
                    e.last = 1'b0;
                    res    = put(res, res_n, e);
                    res_n  = res_n + 2'd1;
                end
                case (mode_next)
                    MODE_STR: end_kind = KIND_STR;
                    MODE_CHR: end_kind = KIND_CHR;
                    MODE_BSL: end_kind = KIND_BSL;
                    default:  end_kind = KIND_END;
                endcase
                e     = '{data: 8'h00, kind: end_kind, last: 1'b1};
                res   = put(res, res_n, e);
                res_n = res_n + 2'd1;
            end
            mode_next = MODE_NORMAL;
            held_next = HELD_NONE;
            esc_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_NORMAL;
            held_reg <= HELD_NONE;
            esc_reg  <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            held_reg <= held_next;
            esc_reg  <= esc_next;
        end
    end

    a_three_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && res_n == 2'd3) |-> in_last)
        else $error("three results from a byte that does not end the text");

    a_reset_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_last) |=> (mode_reg == MODE_NORMAL && held_reg == HELD_NONE && !esc_reg))
        else $error("state not cleared after end of text");

    a_hold_only_in_code: assert property (@(posedge clk) disable iff (!rst_n)
        (held_reg != HELD_NONE) |-> (mode_reg == MODE_NORMAL || mode_reg == MODE_BLOCK))
        else $error("held mark outside code or block comment");

    a_escape_only_in_literal: assert property (@(posedge clk) disable iff (!rst_n)
        esc_reg |-> (mode_reg == MODE_STR || mode_reg == MODE_CHR))
        else $error("escape pending outside a literal");

endmodule
`default_nettype wire

// ===== hdl/css_outq.sv =====
// Result queue: takes up to three results per transaction, delivers one per cycle while out_stall is low.
`default_nettype none
module css_outq (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire css_pkg::res_arr_t res,
    input  wire logic [1:0]        res_n,
    output logic                   full,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [7:0]             out_byte,
    output logic [2:0]             kind,
    output logic                   out_last
);
    import css_pkg::*;

    localparam int PW = $clog2(Q_DEPTH);
    localparam int CW = $clog2(Q_DEPTH + 1);

    res_t          mem [Q_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic [1:0]    push_n;
    logic          pop;
    res_t          head;

    assign push_n = push ? res_n : 2'd0;
    assign pop    = out_valid && !out_stall;
    // room for a full set of results without looking at the output side
    assign full   = count_reg > CW'(Q_DEPTH - MAX_RES);

    assign wr_ptr_next = wr_ptr_reg + PW'(push_n);
    assign rd_ptr_next = rd_ptr_reg + PW'(pop);
    assign count_next  = count_reg + CW'(push_n) - CW'(pop);

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RES; i++)
        begin
            if (2'(i) < push_n)
                mem[wr_ptr_reg + PW'(i)] <= res[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head      = mem[rd_ptr_reg];
    assign out_valid = count_reg != '0;
    assign out_byte  = head.data;
    assign kind      = head.kind;
    assign out_last  = head.last;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(Q_DEPTH))
        else $error("result queue overflow");

    a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (push_n != 2'd0) |=> (count_reg != '0))
        else $error("pushed results not visible");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != CW'(Q_DEPTH)) |-> (PW'(wr_ptr_reg - rd_ptr_reg) == PW'(count_reg)))
        else $error("queue pointers disagree with count");

    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (push_n == 2'd0 && !pop) |=> $stable(count_reg))
        else $error("count moved without push or pop");

endmodule
`default_nettype wire

// ===== hdl/comment_strip_line_splice.sv =====
// Top level of the C comment stripper with line splicing.
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------------
//  input   | in_valid / in_stall  | in_byte, in_last
//  output  | out_valid / out_stall| out_byte, kind, out_last
//
// One byte per cycle while in_stall is low; a byte's results are written
// to a four-entry queue in the cycle it is taken and the first can leave
// on the next cycle. A byte yields zero to three results; the queue drains
// one per cycle when out_stall is low, so in_stall rises after extra results.
// in_stall depends only on queue fill, never combinationally on out_stall.
// Reset clears scanner state and empties the queue.
`default_nettype none
module comment_strip_line_splice (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_last,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      out_byte,
    output logic [2:0]      kind,
    output logic            out_last
);
    import css_pkg::*;

    res_arr_t   res;
    logic [1:0] res_n;
    logic       accept;
    logic       full;

    assign in_stall = full;
    assign accept   = in_valid && !full;

    css_scan u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_byte (in_byte),
        .in_last (in_last),
        .res     (res),
        .res_n   (res_n)
    );

    css_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .res       (res),
        .res_n     (res_n),
        .full      (full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .kind      (kind),
        .out_last  (out_last)
    );

endmodule
`default_nettype wire
